// ----- hw/rtl/symbol_string_tokenizer_unit_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
// All checks are sampled on aclk and are off while aresetn is low.
`ifndef SYMBOL_STRING_TOKENIZER_UNIT_ASSERT_SVH
`define SYMBOL_STRING_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication
`define SST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sst_pkg.sv -----
`default_nettype none

package sst_pkg;

    // Default sizing
    localparam int DEFAULT_POSITION_BITS = 32;
    localparam int DEFAULT_KNOWN_BYTES   = 8;

    // Field widths
    localparam int COUNT_BITS     = 32;
    localparam int WORD_BITS      = 64;
    localparam int LENGTH_BITS    = 4;
    localparam int CFG_INDEX_BITS = 8;

    // Result queue
    localparam int FIFO_DEPTH = 4;

    // Saturation value of the content count
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_KNOWN_WORD   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KNOWN_LENGTH = 8'd1;

    // Lexer modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_SYMBOL = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    // Token kinds
    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_USER   = 2'd1;
    localparam logic [1:0] KIND_KNOWN  = 2'd2;
    localparam logic [1:0] KIND_FINAL  = 2'd3;

    // Final status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOQUOTE = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    // Special bytes
    localparam logic [7:0] QUOTE_BYTE   = 8'h22;
    localparam logic [7:0] LBRACK_BYTE  = 8'h5B;
    localparam logic [7:0] RBRACK_BYTE  = 8'h5D;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [1:0]            token_kind;
        logic [31:0]           token_start;
        logic [COUNT_BITS-1:0] token_length;
        logic [1:0]            lex_status;
        logic                  final_result;
    } out_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]   known_word;
        logic [LENGTH_BITS-1:0] known_length;
    } cfg_t;

    // Up to two results per byte; slot 1 is used only after slot 0
    typedef struct packed {
        logic valid0;
        logic valid1;
        out_t item0;
        out_t item1;
    } lex_res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_symbol_byte(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E && c != QUOTE_BYTE &&
               c != LBRACK_BYTE && c != RBRACK_BYTE;
    endfunction

    function automatic out_t make_token(input logic [1:0] kind,
                                        input logic [31:0] start,
                                        input logic [COUNT_BITS-1:0] len);
        out_t r;
        r.token_kind   = kind;
        r.token_start  = start;
        r.token_length = len;
        r.lex_status   = STATUS_OK;
        r.final_result = 1'b0;
        return r;
    endfunction

    function automatic out_t make_final(input logic [1:0] status);
        out_t r;
        r.token_kind   = KIND_FINAL;
        r.token_start  = '0;
        r.token_length = '0;
        r.lex_status   = status;
        r.final_result = 1'b1;
        return r;
    endfunction

    // Append a result into the next free slot
    function automatic lex_res_t add_result(input lex_res_t r, input out_t x);
        lex_res_t o;
        o = r;
        if (!o.valid0) begin
            o.valid0 = 1'b1;
            o.item0  = x;
        end else begin
            o.valid1 = 1'b1;
            o.item1  = x;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sst_core.sv -----
`default_nettype none

// Lexer state and per-byte classification. All results of one byte are
// produced combinationally from the registered byte and the current state.
module sst_core #(
    parameter int POSITION_BITS = sst_pkg::DEFAULT_POSITION_BITS,
    parameter int KNOWN_BYTES   = sst_pkg::DEFAULT_KNOWN_BYTES
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire sst_pkg::in_t     item,
    input  wire sst_pkg::cfg_t    cfg,
    output sst_pkg::lex_res_t     res
);

    localparam int PREFIX_BITS = 8 * KNOWN_BYTES;
    localparam int CB          = sst_pkg::COUNT_BITS;

    logic [1:0]               mode_reg,   mode_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] begin_reg,  begin_next;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next;
    logic [CB-1:0]            count_reg,  count_next;

    logic [63:0] begin_wide;
    logic [31:0] begin_low;
    logic [63:0] begin_next_wide;
    logic [31:0] begin_next_low;
    logic        taken;
    logic        err_skip;
    logic        known_now;
    logic        known_next;
    logic [7:0]  c;

    // Compare the symbol prefix against the configured known word
    function automatic logic sym_known(input logic [PREFIX_BITS-1:0] pfx,
                                       input logic [CB-1:0] cnt,
                                       input sst_pkg::cfg_t k);
        logic hit;
        hit = (k.known_length != '0) &&
              (CB'(k.known_length) <= CB'(KNOWN_BYTES)) &&
              (cnt == CB'(k.known_length));
        for (int i = 0; i < KNOWN_BYTES; i++) begin
            if (4'(i) < k.known_length && pfx[8*i +: 8] != k.known_word[8*i +: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    assign c               = item.char_byte;
    assign begin_wide      = 64'(begin_reg);
    assign begin_low       = begin_wide[31:0];
    assign known_now       = sym_known(prefix_reg, count_reg, cfg);

    // Next state and results for the byte in the input register
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg + POSITION_BITS'(1);
        begin_next  = begin_reg;
        prefix_next = prefix_reg;
        count_next  = count_reg;
        res         = '0;
        taken       = 1'b0;
        err_skip    = 1'b0;

        unique case (mode_reg)
            sst_pkg::MODE_ERROR: begin
                // drop bytes until the end of the stream
                err_skip = 1'b1;
                pos_next = pos_reg;
            end
            sst_pkg::MODE_STRING: begin
                taken = 1'b1;
                if (c == sst_pkg::QUOTE_BYTE) begin
                    res = sst_pkg::add_result(res,
                        sst_pkg::make_token(sst_pkg::KIND_STRING, begin_low, count_reg));
                    mode_next  = sst_pkg::MODE_IDLE;
                    count_next = '0;
                end else if (count_reg != sst_pkg::COUNT_MAX) begin
                    count_next = count_reg + CB'(1);
                end
            end
            sst_pkg::MODE_SYMBOL: begin
                if (sst_pkg::is_symbol_byte(c)) begin
                    taken = 1'b1;
                    for (int i = 0; i < KNOWN_BYTES; i++) begin
                        if (count_reg == CB'(i)) begin
                            prefix_next[8*i +: 8] = prefix_reg[8*i +: 8] | c;
                        end
                    end
                    if (count_reg != sst_pkg::COUNT_MAX) begin
                        count_next = count_reg + CB'(1);
                    end
                end else begin
                    res = sst_pkg::add_result(res, sst_pkg::make_token(
                        known_now ? sst_pkg::KIND_KNOWN : sst_pkg::KIND_USER,
                        begin_low, count_reg));
                    mode_next   = sst_pkg::MODE_IDLE;
                    count_next  = '0;
                    prefix_next = '0;
                end
            end
            sst_pkg::MODE_IDLE: begin
            end
        endcase

        // Byte seen between tokens
        if (!err_skip && !taken) begin
            if (sst_pkg::is_blank(c)) begin
            end else if (c == sst_pkg::QUOTE_BYTE) begin
                mode_next  = sst_pkg::MODE_STRING;
                begin_next = pos_reg;
                count_next = '0;
            end else if (sst_pkg::is_symbol_byte(c) && !sst_pkg::is_digit(c)) begin
                mode_next   = sst_pkg::MODE_SYMBOL;
                begin_next  = pos_reg;
                prefix_next = PREFIX_BITS'(c);
                count_next  = CB'(1);
            end else begin
                res = sst_pkg::add_result(res,
                    sst_pkg::make_final(sst_pkg::STATUS_UNKNOWN));
                mode_next = sst_pkg::MODE_ERROR;
            end
        end

        // Token state as it stands after this byte
        begin_next_wide = 64'(begin_next);
        begin_next_low  = begin_next_wide[31:0];
        known_next      = sym_known(prefix_next, count_next, cfg);

        // End of stream: flush symbol token; status unless error; clear state
        if (item.end_of_text) begin
            if (!err_skip) begin
                if (mode_next == sst_pkg::MODE_SYMBOL) begin
                    res = sst_pkg::add_result(res, sst_pkg::make_token(
                        known_next ? sst_pkg::KIND_KNOWN : sst_pkg::KIND_USER,
                        begin_next_low, count_next));
                    res = sst_pkg::add_result(res,
                        sst_pkg::make_final(sst_pkg::STATUS_OK));
                end else if (mode_next == sst_pkg::MODE_STRING) begin
                    res = sst_pkg::add_result(res,
                        sst_pkg::make_final(sst_pkg::STATUS_NOQUOTE));
                end else if (mode_next == sst_pkg::MODE_IDLE) begin
                    res = sst_pkg::add_result(res,
                        sst_pkg::make_final(sst_pkg::STATUS_OK));
                end
            end
            mode_next   = sst_pkg::MODE_IDLE;
            pos_next    = '0;
            begin_next  = '0;
            prefix_next = '0;
            count_next  = '0;
        end
    end

    // Stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= sst_pkg::MODE_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            prefix_reg <= '0;
            count_reg  <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            prefix_reg <= prefix_next;
            count_reg  <= count_next;
        end
    end

`include "symbol_string_tokenizer_unit_assert.svh"

    `SST_ASSERT_NOW(a_slot_order, res.valid1, res.valid0, "second result without first")
    `SST_ASSERT_NOW(a_pair_ends_final, res.valid1, res.item1.final_result && !res.item0.final_result, "two-result byte not closed by final status")
    `SST_ASSERT_NEXT(a_error_holds_pos, fire && mode_reg == sst_pkg::MODE_ERROR && !item.end_of_text, $stable(pos_reg) && mode_reg == sst_pkg::MODE_ERROR, "dropped byte moved lexer state")

endmodule

`default_nettype wire

// ----- hw/rtl/sst_fifo.sv -----
`default_nettype none

// Result queue: up to two in per cycle, one result out per ready cycle.
module sst_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_en,
    input  wire sst_pkg::lex_res_t push_res,
    output logic                   room,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sst_pkg::out_t          m_data
);

    localparam int DEPTH    = sst_pkg::FIFO_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sst_pkg::out_t         mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;
    logic                  push_a;
    logic                  push_b;
    logic                  pop;

    assign push_a  = push_en && push_res.valid0;
    assign push_b  = push_en && push_res.valid1;
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    // room for a full two-result byte
    assign room    = (count_reg <= CNT_BITS'(DEPTH - 2));

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_a) + PTR_BITS'(push_b);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_a) + CNT_BITS'(push_b) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem[wr_ptr_reg] <= push_res.item0;
        end
        if (push_b) begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push_res.item1;
        end
    end

`include "symbol_string_tokenizer_unit_assert.svh"

    `SST_ASSERT_NOW(a_no_overflow, push_en, room, "push without room for two results")
    `SST_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

// ----- hw/rtl/symbol_string_tokenizer_unit.sv -----
`default_nettype none

// Byte-serial s-expression tokenizer.
// s_ channel: one source byte per transaction (s_data.char_byte) with
//   s_data.end_of_text marking the last byte of a stream.
// m_ channel: token and final-status transactions, in stream order.
// cfg_ channel: register writes (index 0 known word, index 1 known length);
//   always ready, to be written only while the block is idle.
// A byte's results reach m_ through the input register, then the result
//   queue written from the lexer logic. Throughput: one byte per cycle
//   while the queue has room; the lexer state updates once per byte.
//   A byte yields zero, one or two results; the four-entry result queue
//   drains one per ready cycle, so two-result bytes can slow input.
// Stalls: when m_ready is low the queue fills and s_ready drops once the
//   queue cannot take two more results; nothing is lost or reordered.
// Reset: synchronous on aresetn low; lexer returns to idle with position
//   zero, queue empties, known word and length clear to zero.
module symbol_string_tokenizer_unit #(
    parameter int POSITION_BITS = sst_pkg::DEFAULT_POSITION_BITS,
    parameter int KNOWN_BYTES   = sst_pkg::DEFAULT_KNOWN_BYTES
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire sst_pkg::in_t                         s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output sst_pkg::out_t                             m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sst_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [sst_pkg::WORD_BITS-1:0]        cfg_data
);

    logic              in_valid_reg, in_valid_next;
    sst_pkg::in_t      in_item_reg;
    sst_pkg::cfg_t     cfg_reg;
    sst_pkg::lex_res_t lex_res;
    logic              room;
    logic              proc_fire;
    logic              in_take;

    // Input register handshake
    assign proc_fire     = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || proc_fire;
    assign in_take       = s_valid && s_ready;
    assign in_valid_next = in_take || (in_valid_reg && !proc_fire);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= s_data;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sst_pkg::REG_KNOWN_WORD: begin
                    cfg_reg.known_word <= cfg_data;
                end
                sst_pkg::REG_KNOWN_LENGTH: begin
                    cfg_reg.known_length <= cfg_data[sst_pkg::LENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sst_core #(
        .POSITION_BITS (POSITION_BITS),
        .KNOWN_BYTES   (KNOWN_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (lex_res)
    );

    sst_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (proc_fire),
        .push_res (lex_res),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
